// File: hw/rtl/gac_pkg.sv
// gac_pkg: shared constants, codes and fixed-point helpers for the
// gaussian alert consensus core. No dependencies.
package gac_pkg;

    localparam int TOPIC_COUNT     = 16;
    localparam int NEIGHBOUR_SLOTS = 8;
    localparam int TOPIC_W         = $clog2(TOPIC_COUNT);
    localparam int SLOT_W          = $clog2(NEIGHBOUR_SLOTS);
    localparam int SLOT_TOTAL      = TOPIC_COUNT * NEIGHBOUR_SLOTS;
    localparam int ADDR_W          = $clog2(SLOT_TOTAL);
    localparam int ACC_W           = 32 + $clog2(NEIGHBOUR_SLOTS + 1);

    localparam int DIV_W  = 64;
    localparam int DEN_W  = 49;
    localparam int PROD_W = 66;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 72;
    localparam int CFG_IDX_W = 3;

    localparam logic [16:0]        Q_ONE  = 17'h10000;
    localparam logic signed [31:0] HALF_Q = 32'sd32768;

    localparam logic [2:0] FUNC_OBSERVE   = 3'd0;
    localparam logic [2:0] FUNC_MESSAGE   = 3'd1;
    localparam logic [2:0] FUNC_PRUNE     = 3'd2;
    localparam logic [2:0] FUNC_QUERY     = 3'd3;
    localparam logic [2:0] FUNC_BROADCAST = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_WIT_PRIOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNI_PRIOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_WIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_HEAR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOST      = 3'd6;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // divide by 65536, rounding toward zero
    function automatic logic signed [PROD_W-1:0] trunc16(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v[PROD_W-1] ? v + 66'sd65535 : v;
        return t >>> 16;
    endfunction

    function automatic logic [31:0] age_of(input logic [31:0] now, input logic [31:0] stamp);
        return (now >= stamp) ? now - stamp : 32'd0;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [TOPIC_W-1:0] t,
                                                    input logic [SLOT_W-1:0] s);
        return ADDR_W'(ADDR_W'(t) * ADDR_W'(NEIGHBOUR_SLOTS) + ADDR_W'(s));
    endfunction

endpackage

// File: hw/rtl/gaussian_alert_consensus_core.sv
// gaussian_alert_consensus_core: per-topic Gaussian belief store with a sequencer
// around one shared 33x33 multiplier and the gac_div divider. Uses gac_pkg, gac_div.
// A message request runs up to two divisions; prune walks every slot; query reads every
// neighbour slot of its topic; broadcast emits one belief per known topic and skips the
// others. Output stalls hold the sequencer in S_EMIT_OUT. One request at a time; a result
// waiting in the output register does not block intake.
// Reset (aresetn, synchronous): clears config to defaults, topic flags, slot valid bits.
module gaussian_alert_consensus_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ticks, topic_id, neighbour_slot, decision_bit, witness_bit,
    // sender_mean, sender_precision, zero pad
    input  logic [gac_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [2:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_topic, belief_mean, belief_precision, decided_present, own_witness, zero pad
    output logic [gac_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DISPATCH  = 5'd1;
    localparam logic [4:0] S_MSG0      = 5'd2;
    localparam logic [4:0] S_MSG_DIV   = 5'd3;
    localparam logic [4:0] S_WAIT_DIV1 = 5'd4;
    localparam logic [4:0] S_ETA_MUL   = 5'd5;
    localparam logic [4:0] S_ETA       = 5'd6;
    localparam logic [4:0] S_CAP       = 5'd7;
    localparam logic [4:0] S_CAP_DIV   = 5'd8;
    localparam logic [4:0] S_WAIT_DIV2 = 5'd9;
    localparam logic [4:0] S_DAMP      = 5'd10;
    localparam logic [4:0] S_DAMP1     = 5'd11;
    localparam logic [4:0] S_DAMP2     = 5'd12;
    localparam logic [4:0] S_DAMP3     = 5'd13;
    localparam logic [4:0] S_DAMP4     = 5'd14;
    localparam logic [4:0] S_STORE     = 5'd15;
    localparam logic [4:0] S_PRUNE_RD  = 5'd16;
    localparam logic [4:0] S_PRUNE_CMP = 5'd17;
    localparam logic [4:0] S_BC_SCAN   = 5'd18;
    localparam logic [4:0] S_EMIT_INIT = 5'd19;
    localparam logic [4:0] S_EMIT_RD   = 5'd20;
    localparam logic [4:0] S_EMIT_ACC  = 5'd21;
    localparam logic [4:0] S_EMIT_DIV  = 5'd22;
    localparam logic [4:0] S_EMIT_WAIT = 5'd23;
    localparam logic [4:0] S_EMIT_OUT  = 5'd24;

    logic [4:0] state_reg, state_next;

    // configuration
    logic [31:0] wit_prior_reg, uni_prior_reg, variance_reg, cap_wit_reg, cap_hear_reg;
    logic [16:0] gain_reg;
    logic [29:0] lost_reg;

    // request fields
    logic [2:0]         func_reg;
    logic [31:0]        now_reg;
    logic [3:0]         topic_reg;
    logic [2:0]         slot_reg;
    logic               dec_reg;
    logic               wit_reg;
    logic signed [31:0] mu_reg;
    logic [31:0]        plam_reg;

    // state
    logic [gac_pkg::TOPIC_COUNT-1:0] topic_known_reg, topic_witness_reg;
    logic signed [31:0] prior_info_reg [gac_pkg::TOPIC_COUNT];
    logic [31:0]        prior_prec_reg [gac_pkg::TOPIC_COUNT];
    logic [gac_pkg::SLOT_TOTAL-1:0] slot_valid_reg;
    logic signed [31:0] eta_mem   [gac_pkg::SLOT_TOTAL];
    logic [31:0]        lam_mem   [gac_pkg::SLOT_TOTAL];
    logic [31:0]        stamp_mem [gac_pkg::SLOT_TOTAL];
    logic signed [31:0] eta_rd_reg;
    logic [31:0]        lam_rd_reg, stamp_rd_reg;

    // datapath
    logic signed [31:0]                  m_eta_reg;
    logic [31:0]                         m_lam_reg;
    logic signed [gac_pkg::PROD_W-1:0]   acc_reg;
    logic signed [gac_pkg::PROD_W-1:0]   mul_p_reg;
    logic signed [32:0]                  mul_a, mul_b;
    logic signed [gac_pkg::ACC_W-1:0]    eta_acc_reg;
    logic [gac_pkg::ACC_W-1:0]           lam_acc_reg;
    logic signed [31:0]                  mean_reg;
    logic                                unk_reg;
    logic [gac_pkg::TOPIC_W-1:0]         tcnt_reg;
    logic [gac_pkg::SLOT_W-1:0]          scnt_reg;
    logic [gac_pkg::ADDR_W-1:0]          pcnt_reg;

    // divider
    logic                                div_start, div_done;
    logic signed [gac_pkg::DIV_W-1:0]    div_num, div_quot;
    logic [gac_pkg::DEN_W-1:0]           div_den;

    // output
    logic                              m_tvalid_reg, m_tlast_reg;
    logic [gac_pkg::M_TDATA_W-1:0]     m_tdata_reg;

    logic                           s_acc, out_load, topic_ok, slot_ok, known_above, is_query;
    logic [gac_pkg::TOPIC_W-1:0]    tidx;
    logic [gac_pkg::ADDR_W-1:0]     msg_addr, rd_addr;
    logic [31:0]                    cap_val;
    logic [16:0]                    gain, gain_inv;
    logic                           live;
    logic [31:0]                    lam_sat;
    logic                           decided;
    logic                           own_wit;
    logic signed [gac_pkg::PROD_W-1:0] damp_sum;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign topic_ok  = 32'(topic_reg) < gac_pkg::TOPIC_COUNT;
    assign slot_ok   = 32'(slot_reg) < gac_pkg::NEIGHBOUR_SLOTS;
    assign tidx      = topic_reg[gac_pkg::TOPIC_W-1:0];
    assign msg_addr  = gac_pkg::slot_addr(tidx, slot_reg[gac_pkg::SLOT_W-1:0]);
    assign cap_val   = wit_reg ? cap_wit_reg : cap_hear_reg;
    assign gain      = (gain_reg > gac_pkg::Q_ONE) ? gac_pkg::Q_ONE : gain_reg;
    assign gain_inv  = gac_pkg::Q_ONE - gain;
    assign is_query  = (func_reg == gac_pkg::FUNC_QUERY);
    assign known_above = |((topic_known_reg >> tcnt_reg) >> 1);
    assign live      = slot_valid_reg[rd_addr] &&
                       (gac_pkg::age_of(now_reg, stamp_rd_reg) <= {2'b00, lost_reg});
    assign damp_sum  = acc_reg + mul_p_reg;

    assign lam_sat  = (|lam_acc_reg[gac_pkg::ACC_W-1:32]) ? 32'hFFFFFFFF : lam_acc_reg[31:0];
    assign decided  = is_query && (mean_reg > gac_pkg::HALF_Q);
    assign own_wit  = unk_reg ? 1'b0 : topic_witness_reg[tcnt_reg];
    assign out_load = (state_reg == S_EMIT_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        unique case (state_reg)
            S_PRUNE_RD, S_PRUNE_CMP: rd_addr = pcnt_reg;
            S_EMIT_RD, S_EMIT_ACC:   rd_addr = gac_pkg::slot_addr(tcnt_reg, scnt_reg);
            default:                 rd_addr = msg_addr;
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MSG0: begin
                mul_a = {1'b0, plam_reg};
                mul_b = {1'b0, variance_reg};
            end
            S_ETA_MUL: begin
                mul_a = {1'b0, m_lam_reg};
                mul_b = {mu_reg[31], mu_reg};
            end
            S_CAP: begin
                mul_a = {m_eta_reg[31], m_eta_reg};
                mul_b = {1'b0, cap_val};
            end
            S_DAMP: begin
                mul_a = 33'(gain);
                mul_b = {m_eta_reg[31], m_eta_reg};
            end
            S_DAMP1: begin
                mul_a = 33'(gain_inv);
                mul_b = {eta_rd_reg[31], eta_rd_reg};
            end
            S_DAMP2: begin
                mul_a = 33'(gain);
                mul_b = {1'b0, m_lam_reg};
            end
            S_DAMP3: begin
                mul_a = 33'(gain_inv);
                mul_b = {1'b0, lam_rd_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_MSG_DIV: begin
                div_start = 1'b1;
                div_num   = {16'd0, plam_reg, 16'd0};
                div_den   = gac_pkg::DEN_W'(gac_pkg::Q_ONE) +
                            gac_pkg::DEN_W'(mul_p_reg[63:16]);
            end
            S_CAP_DIV: begin
                div_start = 1'b1;
                div_num   = mul_p_reg[gac_pkg::DIV_W-1:0];
                div_den   = gac_pkg::DEN_W'(m_lam_reg);
            end
            S_EMIT_DIV: begin
                div_start = (lam_acc_reg != '0);
                div_num   = {{(gac_pkg::DIV_W - gac_pkg::ACC_W - 16){eta_acc_reg[gac_pkg::ACC_W-1]}},
                             eta_acc_reg, 16'd0};
                div_den   = gac_pkg::DEN_W'(lam_acc_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_acc) state_next = S_DISPATCH;
            S_DISPATCH: begin
                unique case (func_reg)
                    gac_pkg::FUNC_MESSAGE:   state_next = (topic_ok && slot_ok) ? S_MSG0 : S_IDLE;
                    gac_pkg::FUNC_PRUNE:     state_next = S_PRUNE_RD;
                    gac_pkg::FUNC_QUERY:     state_next = (topic_ok && topic_known_reg[tidx]) ?
                                                          S_EMIT_INIT : S_EMIT_OUT;
                    gac_pkg::FUNC_BROADCAST: state_next = S_BC_SCAN;
                    default:                 state_next = S_IDLE;
                endcase
            end
            S_MSG0:      state_next = (plam_reg == 32'd0) ? S_CAP : S_MSG_DIV;
            S_MSG_DIV:   state_next = S_WAIT_DIV1;
            S_WAIT_DIV1: if (div_done) state_next = S_ETA_MUL;
            S_ETA_MUL:   state_next = S_ETA;
            S_ETA:       state_next = S_CAP;
            S_CAP:       state_next = (m_lam_reg > cap_val) ? S_CAP_DIV : S_DAMP;
            S_CAP_DIV:   state_next = S_WAIT_DIV2;
            S_WAIT_DIV2: if (div_done) state_next = S_DAMP;
            S_DAMP:      state_next = slot_valid_reg[msg_addr] ? S_DAMP1 : S_STORE;
            S_DAMP1:     state_next = S_DAMP2;
            S_DAMP2:     state_next = S_DAMP3;
            S_DAMP3:     state_next = S_DAMP4;
            S_DAMP4:     state_next = S_STORE;
            S_STORE:     state_next = S_IDLE;
            S_PRUNE_RD:  state_next = S_PRUNE_CMP;
            S_PRUNE_CMP: state_next = (pcnt_reg == gac_pkg::ADDR_W'(gac_pkg::SLOT_TOTAL - 1)) ?
                                      S_IDLE : S_PRUNE_RD;
            S_BC_SCAN: begin
                if (topic_known_reg[tcnt_reg]) begin
                    state_next = S_EMIT_INIT;
                end else if (tcnt_reg == gac_pkg::TOPIC_W'(gac_pkg::TOPIC_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_INIT: state_next = S_EMIT_RD;
            S_EMIT_RD:   state_next = S_EMIT_ACC;
            S_EMIT_ACC:  state_next = (scnt_reg == gac_pkg::SLOT_W'(gac_pkg::NEIGHBOUR_SLOTS - 1)) ?
                                      S_EMIT_DIV : S_EMIT_RD;
            S_EMIT_DIV:  state_next = (lam_acc_reg == '0) ? S_EMIT_OUT : S_EMIT_WAIT;
            S_EMIT_WAIT: if (div_done) state_next = S_EMIT_OUT;
            S_EMIT_OUT: begin
                if (out_load) begin
                    state_next = (is_query || !known_above) ? S_IDLE : S_BC_SCAN;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            wit_prior_reg     <= 32'd6553600;
            uni_prior_reg     <= 32'd16384;
            variance_reg      <= 32'd16384;
            cap_wit_reg       <= 32'd655360;
            cap_hear_reg      <= 32'd131072;
            gain_reg          <= 17'd32768;
            lost_reg          <= 30'd3000;
            topic_known_reg   <= '0;
            topic_witness_reg <= '0;
            slot_valid_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    gac_pkg::REG_WIT_PRIOR: wit_prior_reg <= cfg_data;
                    gac_pkg::REG_UNI_PRIOR: uni_prior_reg <= cfg_data;
                    gac_pkg::REG_VARIANCE:  variance_reg  <= cfg_data;
                    gac_pkg::REG_CAP_WIT:   cap_wit_reg   <= cfg_data;
                    gac_pkg::REG_CAP_HEAR:  cap_hear_reg  <= cfg_data;
                    gac_pkg::REG_DAMP_GAIN: gain_reg      <= cfg_data[16:0];
                    gac_pkg::REG_LOST:      lost_reg      <= cfg_data[29:0];
                    default: ;
                endcase
            end
            if (state_reg == S_DISPATCH && func_reg == gac_pkg::FUNC_OBSERVE && topic_ok) begin
                topic_known_reg[tidx]   <= 1'b1;
                topic_witness_reg[tidx] <= wit_reg;
            end
            if (state_reg == S_MSG0 && !topic_known_reg[tidx]) begin
                topic_known_reg[tidx]   <= 1'b1;
                topic_witness_reg[tidx] <= 1'b0;
            end
            if (state_reg == S_STORE) begin
                slot_valid_reg[msg_addr] <= 1'b1;
            end
            if (state_reg == S_PRUNE_CMP && slot_valid_reg[pcnt_reg] &&
                gac_pkg::age_of(now_reg, stamp_rd_reg) > {lost_reg, 2'b00}) begin
                slot_valid_reg[pcnt_reg] <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // slot memories
    always_ff @(posedge aclk) begin
        if (state_reg == S_STORE) begin
            eta_mem[msg_addr]   <= m_eta_reg;
            lam_mem[msg_addr]   <= m_lam_reg;
            stamp_mem[msg_addr] <= now_reg;
        end
        eta_rd_reg   <= eta_mem[rd_addr];
        lam_rd_reg   <= lam_mem[rd_addr];
        stamp_rd_reg <= stamp_mem[rd_addr];
    end

    // datapath
    always_ff @(posedge aclk) begin
        mul_p_reg <= gac_pkg::PROD_W'(mul_a * mul_b);
        if (s_acc) begin
            func_reg  <= s_tuser;
            now_reg   <= s_tdata[31:0];
            topic_reg <= s_tdata[35:32];
            slot_reg  <= s_tdata[38:36];
            dec_reg   <= s_tdata[39];
            wit_reg   <= s_tdata[40];
            mu_reg    <= s_tdata[72:41];
            plam_reg  <= s_tdata[104:73];
        end
        unique case (state_reg)
            S_DISPATCH: begin
                pcnt_reg <= '0;
                if (func_reg == gac_pkg::FUNC_OBSERVE && topic_ok) begin
                    if (wit_reg) begin
                        prior_prec_reg[tidx] <= wit_prior_reg;
                        prior_info_reg[tidx] <= (dec_reg == 1'b0) ? 32'sd0 :
                            gac_pkg::sat32(gac_pkg::PROD_W'(wit_prior_reg));
                    end else begin
                        prior_prec_reg[tidx] <= uni_prior_reg;
                        prior_info_reg[tidx] <= {1'b0, uni_prior_reg[31:1]};
                    end
                end
                if (func_reg == gac_pkg::FUNC_BROADCAST) begin
                    tcnt_reg <= '0;
                end else begin
                    tcnt_reg <= tidx;
                end
                unk_reg     <= 1'b1;
                mean_reg    <= gac_pkg::HALF_Q;
                lam_acc_reg <= '0;
            end
            S_MSG0: begin
                if (!topic_known_reg[tidx]) begin
                    prior_prec_reg[tidx] <= uni_prior_reg;
                    prior_info_reg[tidx] <= {1'b0, uni_prior_reg[31:1]};
                end
                m_eta_reg <= '0;
                m_lam_reg <= '0;
            end
            S_WAIT_DIV1: if (div_done) m_lam_reg <= div_quot[31:0];
            S_ETA:       m_eta_reg <= gac_pkg::sat32(gac_pkg::trunc16(mul_p_reg));
            S_WAIT_DIV2: begin
                if (div_done) begin
                    m_eta_reg <= div_quot[31:0];
                    m_lam_reg <= cap_val;
                end
            end
            S_DAMP1:     acc_reg <= mul_p_reg;
            S_DAMP2:     m_eta_reg <= gac_pkg::sat32(gac_pkg::trunc16(damp_sum));
            S_DAMP3:     acc_reg <= mul_p_reg;
            S_DAMP4:     m_lam_reg <= damp_sum[47:16];
            S_PRUNE_CMP: pcnt_reg <= pcnt_reg + gac_pkg::ADDR_W'(1);
            S_BC_SCAN: begin
                if (!topic_known_reg[tcnt_reg]) begin
                    tcnt_reg <= tcnt_reg + gac_pkg::TOPIC_W'(1);
                end
            end
            S_EMIT_INIT: begin
                unk_reg     <= 1'b0;
                scnt_reg    <= '0;
                eta_acc_reg <= gac_pkg::ACC_W'(prior_info_reg[tcnt_reg]);
                lam_acc_reg <= gac_pkg::ACC_W'(prior_prec_reg[tcnt_reg]);
            end
            S_EMIT_ACC: begin
                if (live) begin
                    eta_acc_reg <= eta_acc_reg + gac_pkg::ACC_W'(eta_rd_reg);
                    lam_acc_reg <= lam_acc_reg + gac_pkg::ACC_W'(lam_rd_reg);
                end
                scnt_reg <= scnt_reg + gac_pkg::SLOT_W'(1);
            end
            S_EMIT_DIV:  mean_reg <= gac_pkg::HALF_Q;
            S_EMIT_WAIT: begin
                if (div_done) begin
                    mean_reg <= gac_pkg::sat32({{2{div_quot[gac_pkg::DIV_W-1]}}, div_quot});
                end
            end
            S_EMIT_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= {2'b00, own_wit, decided, lam_sat, mean_reg,
                                    is_query ? topic_reg : 4'(tcnt_reg)};
                    m_tlast_reg <= is_query || !known_above;
                    tcnt_reg    <= tcnt_reg + gac_pkg::TOPIC_W'(1);
                end
            end
            default: ;
        endcase
    end

    gac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: hw/rtl/gac_div.sv
// gac_div: shared restoring divider, one quotient bit per cycle,
// signed dividend, unsigned divisor, quotient truncated toward zero. Uses gac_pkg.
module gac_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [gac_pkg::DIV_W-1:0]       num,
    input  logic        [gac_pkg::DEN_W-1:0]       den,
    output logic                                   done,
    output logic signed [gac_pkg::DIV_W-1:0]       quot
);

    logic                        run_reg;
    logic                        done_reg;
    logic [6:0]                  cnt_reg;
    logic                        neg_reg;
    logic [gac_pkg::DIV_W-1:0]   num_reg;
    logic [gac_pkg::DEN_W-1:0]   rem_reg;
    logic [gac_pkg::DEN_W-1:0]   den_reg;
    logic [gac_pkg::DEN_W:0]     rem_sh;
    logic                        ge;
    logic [gac_pkg::DEN_W:0]     rem_sub;

    assign rem_sh  = {rem_reg, num_reg[gac_pkg::DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(gac_pkg::DIV_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[gac_pkg::DIV_W-1];
            num_reg <= num[gac_pkg::DIV_W-1] ? -num : num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (run_reg) begin
            num_reg <= {num_reg[gac_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? rem_sub[gac_pkg::DEN_W-1:0] : rem_sh[gac_pkg::DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -num_reg : num_reg;

endmodule

// File: bench/tb_gaussian_alert_consensus_core.sv
// Self-checking bench for gaussian_alert_consensus_core: directed and random requests,
// a bit-accurate belief predictor, stalls on both stream sides. Depends on gac_pkg and the core.
module tb_gaussian_alert_consensus_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [2:0]         func;
        logic [31:0]        now;
        logic [3:0]         topic;
        logic [2:0]         slot;
        logic               decision;
        logic               witness;
        logic signed [31:0] mean;
        logic [31:0]        prec;
    } req_t;

    typedef struct {
        logic [3:0]         topic;
        logic signed [31:0] mean;
        logic [31:0]        prec;
        logic               decided;
        logic               witness;
        logic               last;
    } belief_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [gac_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [2:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [gac_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [gac_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [31:0]                     cfg_data = '0;

    gaussian_alert_consensus_core dut (.*);

    // predictor state
    logic [31:0]        wit_prior, uni_prior, variance, cap_wit, cap_hear;
    logic [16:0]        damp_gain;
    logic [29:0]        lost_ticks;
    bit                 known [gac_pkg::TOPIC_COUNT];
    bit                 own_wit [gac_pkg::TOPIC_COUNT];
    logic signed [31:0] prior_info [gac_pkg::TOPIC_COUNT];
    logic [31:0]        prior_prec [gac_pkg::TOPIC_COUNT];
    bit                 slot_ok [gac_pkg::SLOT_TOTAL];
    logic signed [31:0] slot_eta [gac_pkg::SLOT_TOTAL];
    logic [31:0]        slot_lam [gac_pkg::SLOT_TOTAL];
    logic [31:0]        slot_stamp [gac_pkg::SLOT_TOTAL];

    req_t    pending_reqs [$];
    belief_t expected_beliefs [$];
    req_t    cur_req;
    bit      calm = 1'b0;
    int      errors = 0, accepted = 0, checked = 0, reg_writes = 0;
    logic [31:0] ticks = 32'd1000;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d requests accepted, %0d beliefs pending",
                 accepted, expected_beliefs.size());
        $display("tb_gaussian_alert_consensus_core failed");
        $finish;
    end

    function automatic wide_t wu(input logic [31:0] x);
        return $signed({96'b0, x});
    endfunction

    function automatic wide_t ws(input logic signed [31:0] x);
        wide_t r;
        r = x;
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input wide_t v);
        if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] age(input logic [31:0] now, input logic [31:0] stamp);
        return (now >= stamp) ? now - stamp : 32'd0;
    endfunction

    function automatic void set_uninformed(input int t);
        prior_prec[t] = uni_prior;
        prior_info[t] = $signed({1'b0, uni_prior[31:1]});
    endfunction

    function automatic void add_expected(input belief_t b);
        expected_beliefs.insert(expected_beliefs.size(), b);
    endfunction

    function automatic belief_t belief_of(input int t, input logic [31:0] now, input bit query);
        belief_t b;
        wide_t eta, lam;
        int k;
        eta = ws(prior_info[t]);
        lam = wu(prior_prec[t]);
        for (int s = 0; s < gac_pkg::NEIGHBOUR_SLOTS; s++) begin
            k = t * gac_pkg::NEIGHBOUR_SLOTS + s;
            if (slot_ok[k] && age(now, slot_stamp[k]) <= {2'b0, lost_ticks}) begin
                eta += ws(slot_eta[k]);
                lam += wu(slot_lam[k]);
            end
        end
        b.topic = t[3:0];
        b.mean = (lam != 0) ? clamp32((eta * 65536) / lam) : gac_pkg::HALF_Q;
        b.prec = (lam > wu(32'hFFFFFFFF)) ? 32'hFFFFFFFF : lam[31:0];
        b.decided = query && (b.mean > gac_pkg::HALF_Q);
        b.witness = own_wit[t];
        b.last = 1'b0;
        return b;
    endfunction

    function automatic void apply_message(input req_t r);
        wide_t eta, lam, q, cap, g;
        int k;
        eta = 0;
        lam = 0;
        cap = wu(r.witness ? cap_wit : cap_hear);
        if (!known[r.topic]) begin
            known[r.topic] = 1;
            own_wit[r.topic] = 0;
            set_uninformed(r.topic);
        end
        if (r.prec != 0) begin
            q = (wu(r.prec) * wu(variance)) >>> 16;
            lam = (wu(r.prec) <<< 16) / (65536 + q);
            eta = ws(clamp32((lam * ws(r.mean)) / 65536));
        end
        if (lam > cap) begin
            eta = (eta * cap) / lam;
            lam = cap;
        end
        k = r.topic * gac_pkg::NEIGHBOUR_SLOTS + r.slot;
        if (slot_ok[k]) begin
            g = (damp_gain > 17'd65536) ? 65536 : wu({15'b0, damp_gain});
            eta = (g * eta + (65536 - g) * ws(slot_eta[k])) / 65536;
            lam = (g * lam + (65536 - g) * wu(slot_lam[k])) >>> 16;
        end
        slot_eta[k] = clamp32(eta);
        slot_lam[k] = lam[31:0];
        slot_stamp[k] = r.now;
        slot_ok[k] = 1;
    endfunction

    function automatic void predict_beliefs(input req_t r);
        belief_t b;
        int n;
        case (r.func)
            gac_pkg::FUNC_OBSERVE: begin
                known[r.topic] = 1;
                own_wit[r.topic] = r.witness;
                if (r.witness) begin
                    prior_prec[r.topic] = wit_prior;
                    prior_info[r.topic] = r.decision ? clamp32(wu(wit_prior)) : 32'sd0;
                end else begin
                    set_uninformed(r.topic);
                end
            end
            gac_pkg::FUNC_MESSAGE: apply_message(r);
            gac_pkg::FUNC_PRUNE: begin
                for (int k = 0; k < gac_pkg::SLOT_TOTAL; k++)
                    if (slot_ok[k] && {2'b0, age(r.now, slot_stamp[k])} > 34'(lost_ticks) * 4)
                        slot_ok[k] = 0;
            end
            gac_pkg::FUNC_QUERY: begin
                if (known[r.topic]) begin
                    b = belief_of(r.topic, r.now, 1);
                end else begin
                    b = '{r.topic, gac_pkg::HALF_Q, 32'd0, 1'b0, 1'b0, 1'b0};
                end
                b.last = 1;
                add_expected(b);
            end
            gac_pkg::FUNC_BROADCAST: begin
                n = 0;
                for (int t = 0; t < gac_pkg::TOPIC_COUNT; t++)
                    if (known[t]) begin
                        add_expected(belief_of(t, r.now, 0));
                        n++;
                    end
                if (n > 0) expected_beliefs[expected_beliefs.size() - 1].last = 1;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on belief %0d: %s got %0h want %0h", checked, field, got, want);
        errors++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_beliefs(cur_req);
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_req.func;
                    s_tdata <= {7'b0, cur_req.prec, cur_req.mean, cur_req.witness,
                                cur_req.decision, cur_req.slot, cur_req.topic, cur_req.now};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        belief_t b;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_beliefs.size() == 0) begin
                    report_mismatch("unexpected topic", 32'(m_tdata[3:0]), 32'd0);
                end else begin
                    b = expected_beliefs.pop_front();
                    if (m_tdata[3:0] !== b.topic)
                        report_mismatch("topic", 32'(m_tdata[3:0]), 32'(b.topic));
                    if (m_tdata[35:4] !== b.mean) report_mismatch("mean", m_tdata[35:4], b.mean);
                    if (m_tdata[67:36] !== b.prec) report_mismatch("prec", m_tdata[67:36], b.prec);
                    if (m_tdata[68] !== b.decided)
                        report_mismatch("decided", 32'(m_tdata[68]), 32'(b.decided));
                    if (m_tdata[69] !== b.witness)
                        report_mismatch("witness", 32'(m_tdata[69]), 32'(b.witness));
                    if (m_tlast !== b.last) report_mismatch("last", 32'(m_tlast), 32'(b.last));
                    checked++;
                end
            end
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
        end
    end

    task automatic write_reg(input logic [gac_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            gac_pkg::REG_WIT_PRIOR: wit_prior = value;
            gac_pkg::REG_UNI_PRIOR: uni_prior = value;
            gac_pkg::REG_VARIANCE:  variance = value;
            gac_pkg::REG_CAP_WIT:   cap_wit = value;
            gac_pkg::REG_CAP_HEAR:  cap_hear = value;
            gac_pkg::REG_DAMP_GAIN: damp_gain = value[16:0];
            gac_pkg::REG_LOST:      lost_ticks = value[29:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_all(input logic [31:0] v [7]);
        for (int i = 0; i < 7; i++) write_reg(gac_pkg::CFG_IDX_W'(i), v[i]);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push(input logic [2:0] f, input logic [31:0] now, input int t, input int s,
                        input bit d, input bit w, input logic [31:0] mu, input logic [31:0] p);
        req_t r;
        r = '{f, now, t[3:0], s[2:0], d, w, mu, p};
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic push_random(input int count);
        logic [2:0] f;
        logic [31:0] mu, p;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            f = pick < 15 ? gac_pkg::FUNC_OBSERVE : pick < 60 ? gac_pkg::FUNC_MESSAGE :
                pick < 68 ? gac_pkg::FUNC_PRUNE : pick < 90 ? gac_pkg::FUNC_QUERY :
                pick < 96 ? gac_pkg::FUNC_BROADCAST : 3'($urandom_range(5, 7));
            ticks = ($urandom_range(99) < 8) ? $urandom() : ticks + $urandom_range(0, 1500);
            mu = $urandom_range(0, 65536);
            if ($urandom_range(1)) mu = -mu;
            if ($urandom_range(3) == 0) mu = $urandom();
            pick = $urandom_range(9);
            p = pick == 0 ? 32'd0 : pick < 5 ? $urandom_range(1, 32'h40000) : $urandom();
            push(f, ticks, $urandom_range(15), $urandom_range(7), $urandom_range(1),
                 $urandom_range(1), mu, p);
        end
    endtask

    task automatic run_and_settle();
        while (pending_reqs.size() > 0 || s_tvalid || expected_beliefs.size() > 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    initial begin
        wit_prior = 32'd6553600;
        uni_prior = 32'd16384;
        variance = 32'd16384;
        cap_wit = 32'd655360;
        cap_hear = 32'd131072;
        damp_gain = 17'd32768;
        lost_ticks = 30'd3000;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults
        push(gac_pkg::FUNC_BROADCAST, 0, 0, 0, 0, 0, 0, 0);
        push(gac_pkg::FUNC_QUERY, 10, 5, 0, 0, 0, 0, 0);
        push(gac_pkg::FUNC_OBSERVE, 0, 0, 0, 1, 1, 0, 0);
        push(gac_pkg::FUNC_OBSERVE, 0, 1, 0, 0, 1, 0, 0);
        push(gac_pkg::FUNC_OBSERVE, 0, 2, 0, 1, 0, 0, 0);
        push(gac_pkg::FUNC_MESSAGE, 1000, 3, 0, 0, 0, 32'h12345678, 0);
        push(gac_pkg::FUNC_MESSAGE, 1000, 0, 7, 0, 1, 32'h7FFFFFFF, 32'hFFFFFFFF);
        push(gac_pkg::FUNC_MESSAGE, 1000, 0, 7, 0, 1, 32'h80000000, 32'h10000);
        push(gac_pkg::FUNC_MESSAGE, 1000, 1, 1, 0, 0, -32'sd65536, 32'd1);
        push(gac_pkg::FUNC_MESSAGE, 50000, 2, 3, 0, 0, 32'h10000, 32'h30000);
        for (int t = 0; t < 4; t++) push(gac_pkg::FUNC_QUERY, 1000, t, 0, 0, 0, 0, 0);
        push(gac_pkg::FUNC_BROADCAST, 1000, 0, 0, 0, 0, 0, 0);
        push(gac_pkg::FUNC_QUERY, 4001, 0, 0, 0, 0, 0, 0);
        push(gac_pkg::FUNC_PRUNE, 13001, 0, 0, 0, 0, 0, 0);
        push(gac_pkg::FUNC_QUERY, 1000, 0, 0, 0, 0, 0, 0);
        for (int k = 5; k < 8; k++) push(3'(k), 1000, 0, 0, 1, 1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push(gac_pkg::FUNC_QUERY, 1000, 15, 0, 0, 0, 0, 0);
        push_random(200);
        run_and_settle();

        // largest settings, no idling
        write_all('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'd65536, 32'h3FFFFFFF});
        calm = 1'b1;
        push_random(120);
        run_and_settle();
        calm = 1'b0;

        // smallest settings
        write_all('{32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        push_random(90);
        run_and_settle();

        // mid-range random settings
        write_all('{$urandom_range(1, 32'h1000000), $urandom_range(1, 32'h100000),
                    $urandom_range(0, 32'h100000), $urandom_range(0, 32'h1000000),
                    $urandom_range(0, 32'h400000), $urandom_range(0, 65536),
                    $urandom_range(0, 5000)});
        push_random(90);
        run_and_settle();

        $display("%0d requests over 4 register settings (%0d register writes), %0d beliefs checked",
                 accepted, reg_writes, checked);
        if (errors == 0) begin
            $display("tb_gaussian_alert_consensus_core passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_gaussian_alert_consensus_core failed");
        end
        $finish;
    end
endmodule
